// File: rtl/sst_pkg.sv
package sst_pkg;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 1024;

  // Field widths
  localparam int SLOT_W    = 10;
  localparam int KEY_W     = 48;
  localparam int COUNT_W   = 11;
  localparam int CFG_W     = 48;
  localparam int REG_IDX_W = 1;

  // Item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAST_END    = 1'd1;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_index;
    logic [KEY_W-1:0]  span_start;
    logic [KEY_W-1:0]  span_end;
  } out_t;

endpackage

// File: rtl/sorted_start_table_span_lookup.sv
// Sorted start-address table with exact-match span lookup.
//
// Input channel (in_valid / in_stall / in_data) carries two kinds of beat.
// A load beat writes one table slot in the cycle it is accepted and gives
// no result; a load to a slot at or beyond the table depth is dropped.
// A lookup beat binary-searches the first entry_count slots and gives one
// result beat on the output channel (out_valid / out_stall / out_data).
// The table sits in a single-port-read, single-port-write memory; each
// probe is one memory read, and the comparison and the next midpoint are
// worked out in the cycle the read data returns.
// A lookup holds the input channel until its result moves to the output
// register. It makes at most ceil(log2(entry_count + 1)) probes, and on a
// hit that is not the final slot one more read fetches the next slot's
// start. A load does not hold the input channel.
// The output register lets the next item be accepted while a result waits;
// if the receiver keeps stalling, the next lookup waits at its end.
// Configuration (cfg_we / cfg_index / cfg_data) is to be written while
// idle; the block does not enforce it. Reset zeroes the configuration,
// idles the search and empties the output; table is undefined until loaded.
module sorted_start_table_span_lookup #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sst_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sst_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [sst_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SXW = (CW > sst_pkg::SLOT_W) ? CW : sst_pkg::SLOT_W;
  localparam int NXW = (CW > sst_pkg::COUNT_W) ? CW : sst_pkg::COUNT_W;

  logic [sst_pkg::COUNT_W-1:0] entry_count;
  logic [sst_pkg::KEY_W-1:0]   last_end;

  logic                      in_acc;
  logic                      start;
  logic                      busy;
  logic [SXW-1:0]            slot_x;
  logic                      slot_ok;
  logic                      we;
  logic [NXW-1:0]            cnt_x;
  logic [CW-1:0]             count;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [sst_pkg::KEY_W-1:0] rd_data;
  sst_pkg::out_t             res;
  logic                      res_valid;
  logic                      res_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      last_end    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sst_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[sst_pkg::COUNT_W-1:0];
        sst_pkg::REG_LAST_END:    last_end    <= cfg_data[sst_pkg::KEY_W-1:0];
        default: begin
          last_end <= last_end;
        end
      endcase
    end
  end

  // Accept one beat at a time; decode load versus lookup
  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && (in_data.opcode == sst_pkg::OP_LOOKUP);
  assign slot_x   = SXW'(in_data.slot);
  assign slot_ok  = (slot_x < SXW'(TABLE_DEPTH));
  assign we       = in_acc && (in_data.opcode == sst_pkg::OP_LOAD) && slot_ok;

  // Saturate the covered count at the table depth
  assign cnt_x = NXW'(entry_count);
  assign count = (cnt_x > NXW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_x[CW-1:0];

  sst_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (slot_x[IW-1:0]),
    .wdata (in_data.key),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sst_search #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .key       (in_data.key),
    .count     (count),
    .last_end  (last_end),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .busy      (busy)
  );

  // Output register: load when empty or draining this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

// File: rtl/sst_mem.sv
module sst_mem #(
  parameter int DEPTH = sst_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [sst_pkg::KEY_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [sst_pkg::KEY_W-1:0] rdata
);

  logic [sst_pkg::KEY_W-1:0] mem [DEPTH];

  // Write one slot, read one slot with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sst_search.sv
module sst_search #(
  parameter int DEPTH = sst_pkg::TABLE_DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sst_pkg::KEY_W-1:0] key,
  input  logic [CW-1:0]             count,
  input  logic [sst_pkg::KEY_W-1:0] last_end,
  output logic                      rd_en,
  output logic [IW-1:0]             rd_addr,
  input  logic [sst_pkg::KEY_W-1:0] rd_data,
  output sst_pkg::out_t             res,
  output logic                      res_valid,
  input  logic                      res_take,
  output logic                      busy
);

  localparam int XW = (IW > sst_pkg::SLOT_W) ? IW : sst_pkg::SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state;
  logic [sst_pkg::KEY_W-1:0] key_q;
  logic [CW-1:0]             cnt_q;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hiex;
  logic [IW-1:0]             mid_q;
  sst_pkg::out_t             res_q;

  logic          hit;
  logic          less;
  logic          has_next;
  logic          more;
  logic [CW-1:0] mid_ext;
  logic [CW-1:0] cand_lo;
  logic [CW-1:0] cand_hi;
  logic [CW-1:0] mid_c;
  logic [IW-1:0] mid_nx;
  logic [XW-1:0] mid_x;

  // Compare the probed start address against the key
  assign hit      = (rd_data == key_q);
  assign less     = (rd_data < key_q);
  assign mid_ext  = CW'(mid_q);
  assign has_next = ((mid_ext + CW'(1)) < cnt_q);
  assign mid_nx   = mid_q + IW'(1);
  assign mid_x    = XW'(mid_q);

  // Narrow the window: fresh bounds on start, halved bounds after a probe
  always_comb begin
    if (state == S_IDLE) begin
      cand_lo = '0;
      cand_hi = count;
    end else if (less) begin
      cand_lo = mid_ext + CW'(1);
      cand_hi = hiex;
    end else begin
      cand_lo = lo;
      cand_hi = mid_ext;
    end
    more  = (cand_lo < cand_hi);
    mid_c = cand_lo + ((cand_hi - cand_lo - CW'(1)) >> 1);
  end

  // Issue the next probe, or the next slot's start after a hit
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_c[IW-1:0];
    case (state)
      S_IDLE: begin
        rd_en = start && more;
      end
      S_CMP: begin
        if (hit) begin
          rd_en   = has_next;
          rd_addr = mid_nx;
        end else begin
          rd_en = more;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequence the search
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            key_q <= key;
            cnt_q <= count;
            lo    <= cand_lo;
            hiex  <= cand_hi;
            if (more) begin
              mid_q <= mid_c[IW-1:0];
              state <= S_CMP;
            end else begin
              res_q <= '0;
              state <= S_DONE;
            end
          end
        end
        S_CMP: begin
          if (hit) begin
            res_q.found       <= 1'b1;
            res_q.match_index <= mid_x[sst_pkg::SLOT_W-1:0];
            res_q.span_start  <= key_q;
            if (has_next) begin
              state <= S_END;
            end else begin
              res_q.span_end <= last_end;
              state          <= S_DONE;
            end
          end else begin
            lo   <= cand_lo;
            hiex <= cand_hi;
            if (more) begin
              mid_q <= mid_c[IW-1:0];
            end else begin
              res_q <= '0;
              state <= S_DONE;
            end
          end
        end
        S_END: begin
          res_q.span_end <= rd_data - sst_pkg::KEY_W'(1);
          state          <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res       = res_q;
  assign res_valid = (state == S_DONE);
  assign busy      = (state != S_IDLE);

endmodule

// File: rtl/sst_check.sv
module sst_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input sst_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input sst_pkg::out_t out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Busy with the search right after a lookup is taken
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.opcode == sst_pkg::OP_LOOKUP) |=> in_stall)
    else $error("input taken while a lookup is in flight");

  // A miss carries zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      (out_data.match_index == '0) && (out_data.span_start == '0) &&
      (out_data.span_end == '0))
    else $error("miss result with nonzero fields");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind sorted_start_table_span_lookup sst_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
